// ----- design/assert_macros.svh -----
// assertion macros shared by the crosstab checker
// no dependencies; each macro expects clk in scope, and CTT_ASSERT_IMP also rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, masked while reset is high
`define CTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crosstab assertion failed");

// implication on the next cycle, also checked across reset
`define CTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("crosstab assertion failed");

`endif

// ----- design/ctt_pkg.sv -----
// shared types and constants for the class transition crosstab
// no dependencies; imported by every crosstab module but ctt_ram
package ctt_pkg;

  localparam int NUM_CLASSES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int VALUE_BITS      = 16;
  localparam int CODE_BITS       = 23;
  localparam int OUT_BITS        = 32;
  localparam int NET_BITS        = 33;
  localparam int CLS_MAX_BITS    = 8;
  localparam int CODE_SCALE      = 100;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_COUNTED = 3'd0,
    ST_NODATA  = 3'd1,
    ST_RANGE   = 3'd2,
    ST_QUERY   = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic {
    REG_NODATA_ENABLE = 1'b0,
    REG_NODATA_VALUE  = 1'b1
  } reg_idx_t;

  // what the back end has to do with a queued request
  typedef enum logic [1:0] {
    K_REPORT = 2'd0,
    K_COUNT  = 2'd1,
    K_QUERY  = 2'd2,
    K_CLEAR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    status_t                 status;
    logic [CODE_BITS-1:0]    code;
    logic [CLS_MAX_BITS-1:0] e_cls;
    logic [CLS_MAX_BITS-1:0] l_cls;
    logic                    cell_ok;
  } item_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CNT_RD,
    B_CNT_WR,
    B_Q_RD1,
    B_Q_RD2,
    B_Q_OUT,
    B_CLEAR
  } bstate_t;

endpackage

// ----- design/ctt_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module ctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ctt_queue.sv -----
// short request queue between the front and back ends
// depends on ctt_pkg for the request type
module ctt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctt_pkg::item_t push_item,
  input  logic          pop,
  output ctt_pkg::item_t head,
  output logic          empty,
  output logic          full
);
  import ctt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CW'(QUEUE_DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- design/ctt_front.sv -----
// front end: config registers, request accept and classification
// depends on ctt_pkg; feeds ctt_queue
module ctt_front #(
  parameter int NUM_CLASSES = ctt_pkg::NUM_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     command,
  input  logic [ctt_pkg::VALUE_BITS-1:0] earlier_value,
  input  logic [ctt_pkg::VALUE_BITS-1:0] later_value,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [ctt_pkg::VALUE_BITS-1:0] cfg_data,
  input  logic                           q_full,
  input  logic                           sweeping,
  output logic                           busy,
  output logic                           push,
  output ctt_pkg::item_t                 push_item
);
  import ctt_pkg::*;

  logic                  nodata_enable;
  logic [VALUE_BITS-1:0] nodata_value;
  logic                  e_oor;
  logic                  l_oor;
  logic                  is_nodata;
  logic [CODE_BITS-1:0]  pair_code;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nodata_enable <= 1'b0;
      nodata_value  <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NODATA_ENABLE: nodata_enable <= cfg_data[0];
        REG_NODATA_VALUE:  nodata_value  <= cfg_data;
      endcase
    end
  end

  // handshake
  assign busy = q_full | sweeping;
  assign push = start && !busy && (cmd_t'(command) != CMD_NONE);

  // range, no-data and code
  assign e_oor     = (earlier_value >= VALUE_BITS'(NUM_CLASSES));
  assign l_oor     = (later_value >= VALUE_BITS'(NUM_CLASSES));
  assign is_nodata = nodata_enable &&
                     ((earlier_value == nodata_value) || (later_value == nodata_value));
  assign pair_code = CODE_BITS'(earlier_value) * CODE_BITS'(CODE_SCALE) +
                     CODE_BITS'(later_value);

  // classify the request
  always_comb begin
    push_item         = '0;
    push_item.kind    = K_REPORT;
    push_item.status  = ST_RANGE;
    push_item.e_cls   = earlier_value[CLS_MAX_BITS-1:0];
    push_item.l_cls   = later_value[CLS_MAX_BITS-1:0];
    push_item.cell_ok = !l_oor;
    unique case (cmd_t'(command))
      CMD_COUNT: begin
        if (is_nodata) begin
          push_item.status = ST_NODATA;
          push_item.code   = CODE_BITS'(nodata_value);
        end else begin
          push_item.code = pair_code;
          if (!e_oor && !l_oor) begin
            push_item.kind   = K_COUNT;
            push_item.status = ST_COUNTED;
          end
        end
      end
      CMD_QUERY: begin
        if (!e_oor) begin
          push_item.kind   = K_QUERY;
          push_item.status = ST_QUERY;
        end
      end
      CMD_CLEAR: begin
        push_item.kind   = K_CLEAR;
        push_item.status = ST_CLEARED;
      end
      CMD_NONE: begin
        push_item.kind = K_REPORT;
      end
    endcase
  end

endmodule

// ----- design/ctt_back.sv -----
// back end: counter stores, read-modify-write, queries and clearing sweep
// depends on ctt_pkg and ctt_ram; pops requests from ctt_queue
module ctt_back #(
  parameter int NUM_CLASSES = ctt_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_BITS  = ctt_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  ctt_pkg::item_t                      head,
  output logic                                pop,
  output logic                                sweeping,
  output logic                                done,
  output logic [2:0]                          status,
  output logic [ctt_pkg::CODE_BITS-1:0]       transition_code,
  output logic [ctt_pkg::OUT_BITS-1:0]        cell_count,
  output logic [ctt_pkg::OUT_BITS-1:0]        area_earlier,
  output logic [ctt_pkg::OUT_BITS-1:0]        area_later,
  output logic [ctt_pkg::OUT_BITS-1:0]        persistence_count,
  output logic [ctt_pkg::OUT_BITS-1:0]        gains_count,
  output logic [ctt_pkg::OUT_BITS-1:0]        losses_count,
  output logic signed [ctt_pkg::NET_BITS-1:0] net_delta,
  output logic                                class_present
);
  import ctt_pkg::*;

  localparam int CB     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int MB     = 2 * CB;
  localparam int MDEPTH = 1 << MB;
  localparam int TDEPTH = 1 << CB;
  localparam int WIDE   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS + 1;

  // clamp a counter to the 32-bit output range
  function automatic logic [OUT_BITS-1:0] clip32(input logic [COUNT_BITS-1:0] v);
    logic [WIDE-1:0] w;
    w = WIDE'(v);
    return (w > WIDE'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  bstate_t state;
  bstate_t state_next;
  item_t   cur;
  logic [MB-1:0] clr_addr;
  logic [CB-1:0] ce;
  logic [CB-1:0] cl;

  logic [OUT_BITS-1:0] ae_q;
  logic [OUT_BITS-1:0] al_q;
  logic [OUT_BITS-1:0] persist_q;
  logic [OUT_BITS-1:0] gains_q;
  logic [OUT_BITS-1:0] losses_q;
  logic                present_q;

  // store ports
  logic                  m_we;
  logic [MB-1:0]         m_waddr;
  logic [COUNT_BITS-1:0] m_wdata;
  logic [MB-1:0]         m_raddr;
  logic [COUNT_BITS-1:0] m_rdata;
  logic                  t_we;
  logic [CB-1:0]         e_waddr;
  logic [COUNT_BITS-1:0] e_wdata;
  logic [CB-1:0]         e_raddr;
  logic [COUNT_BITS-1:0] e_rdata;
  logic [CB-1:0]         l_waddr;
  logic [COUNT_BITS-1:0] l_wdata;
  logic [CB-1:0]         l_raddr;
  logic [COUNT_BITS-1:0] l_rdata;

  // result being formed
  logic                         emit;
  status_t                      res_status;
  logic [CODE_BITS-1:0]         res_code;
  logic [OUT_BITS-1:0]          res_cell;
  logic [OUT_BITS-1:0]          res_ae;
  logic [OUT_BITS-1:0]          res_al;
  logic [OUT_BITS-1:0]          res_persist;
  logic [OUT_BITS-1:0]          res_gains;
  logic [OUT_BITS-1:0]          res_losses;
  logic signed [NET_BITS-1:0]   res_net;
  logic                         res_present;

  assign ce = cur.e_cls[CB-1:0];
  assign cl = cur.l_cls[CB-1:0];

  // transition matrix, row totals, column totals
  ctt_ram #(.WIDTH(COUNT_BITS), .DEPTH(MDEPTH)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  ctt_ram #(.WIDTH(COUNT_BITS), .DEPTH(TDEPTH)) u_row_tot (
    .clk(clk), .we(t_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  ctt_ram #(.WIDTH(COUNT_BITS), .DEPTH(TDEPTH)) u_col_tot (
    .clk(clk), .we(t_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // state register and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_INIT;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_INIT || state == B_CLEAR) begin
        clr_addr <= clr_addr + MB'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_INIT, B_CLEAR: begin
        if (clr_addr == {MB{1'b1}}) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            K_REPORT: state_next = B_IDLE;
            K_COUNT:  state_next = B_CNT_RD;
            K_QUERY:  state_next = B_Q_RD1;
            K_CLEAR:  state_next = B_CLEAR;
          endcase
        end
      end
      B_CNT_RD: state_next = B_CNT_WR;
      B_CNT_WR: state_next = B_IDLE;
      B_Q_RD1:  state_next = B_Q_RD2;
      B_Q_RD2:  state_next = B_Q_OUT;
      B_Q_OUT:  state_next = B_IDLE;
      default:  state_next = B_INIT;
    endcase
  end

  // outputs of the state machine: store control and result
  always_comb begin
    pop         = (state == B_IDLE) && !q_empty;
    sweeping    = (state == B_INIT);
    m_we        = 1'b0;
    m_waddr     = {ce, cl};
    m_wdata     = sat_inc(m_rdata);
    m_raddr     = (state == B_Q_RD1) ? {ce, ce} : {ce, cl};
    t_we        = 1'b0;
    e_waddr     = ce;
    e_wdata     = sat_inc(e_rdata);
    e_raddr     = ce;
    l_waddr     = cl;
    l_wdata     = sat_inc(l_rdata);
    l_raddr     = (state == B_CNT_RD) ? cl : ce;
    emit        = 1'b0;
    res_status  = ST_COUNTED;
    res_code    = '0;
    res_cell    = '0;
    res_ae      = '0;
    res_al      = '0;
    res_persist = '0;
    res_gains   = '0;
    res_losses  = '0;
    res_net     = '0;
    res_present = 1'b0;
    unique case (state)
      B_INIT, B_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_addr;
        m_wdata = '0;
        t_we    = 1'b1;
        e_waddr = clr_addr[CB-1:0];
        e_wdata = '0;
        l_waddr = clr_addr[CB-1:0];
        l_wdata = '0;
        if (state == B_CLEAR && clr_addr == {MB{1'b1}}) begin
          emit       = 1'b1;
          res_status = ST_CLEARED;
        end
      end
      B_IDLE: begin
        if (!q_empty && head.kind == K_REPORT) begin
          emit       = 1'b1;
          res_status = head.status;
          res_code   = head.code;
        end
      end
      B_CNT_WR: begin
        m_we       = 1'b1;
        t_we       = 1'b1;
        emit       = 1'b1;
        res_status = ST_COUNTED;
        res_code   = cur.code;
      end
      B_Q_OUT: begin
        emit        = 1'b1;
        res_status  = ST_QUERY;
        res_cell    = cur.cell_ok ? clip32(m_rdata) : '0;
        res_ae      = ae_q;
        res_al      = al_q;
        res_persist = persist_q;
        res_gains   = gains_q;
        res_losses  = losses_q;
        res_net     = $signed({1'b0, gains_q}) - $signed({1'b0, losses_q});
        res_present = present_q;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // current request and query partials
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == B_Q_RD2) begin
      ae_q      <= clip32(e_rdata);
      al_q      <= clip32(l_rdata);
      persist_q <= clip32(m_rdata);
      gains_q   <= clip32(l_rdata - m_rdata);
      losses_q  <= clip32(e_rdata - m_rdata);
      present_q <= (e_rdata != '0) || (l_rdata != '0);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      status            <= res_status;
      transition_code   <= res_code;
      cell_count        <= res_cell;
      area_earlier      <= res_ae;
      area_later        <= res_al;
      persistence_count <= res_persist;
      gains_count       <= res_gains;
      losses_count      <= res_losses;
      net_delta         <= res_net;
      class_present     <= res_present;
    end
  end

endmodule

// ----- design/class_transition_crosstab.sv -----
// class transition crosstab: a result strobe follows each accepted request other than
// the unused command; skipped pairs and range errors are answered from idle, counted
// pairs after a read then write of the registered-read counter rams, queries after the
// read states Q_RD1, Q_RD2 and the output state Q_OUT; a 2-deep queue takes requests meanwhile.
// clear zeroes all 4^ceil(log2 NUM_CLASSES) matrix entries (256 at 16 classes), one matrix entry a cycle.
// reset: config to 0, then the same clearing sweep with busy high.
module class_transition_crosstab #(
  parameter int NUM_CLASSES = ctt_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_BITS  = ctt_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [ctt_pkg::VALUE_BITS-1:0]      earlier_value,
  input  logic [ctt_pkg::VALUE_BITS-1:0]      later_value,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [ctt_pkg::VALUE_BITS-1:0]      cfg_data,
  output logic                                done,
  output logic [2:0]                          status,
  output logic [ctt_pkg::CODE_BITS-1:0]       transition_code,
  output logic [ctt_pkg::OUT_BITS-1:0]        cell_count,
  output logic [ctt_pkg::OUT_BITS-1:0]        area_earlier,
  output logic [ctt_pkg::OUT_BITS-1:0]        area_later,
  output logic [ctt_pkg::OUT_BITS-1:0]        persistence_count,
  output logic [ctt_pkg::OUT_BITS-1:0]        gains_count,
  output logic [ctt_pkg::OUT_BITS-1:0]        losses_count,
  output logic signed [ctt_pkg::NET_BITS-1:0] net_delta,
  output logic                                class_present
);
  import ctt_pkg::*;

  logic  push;
  item_t push_item;
  logic  pop;
  item_t head;
  logic  q_empty;
  logic  q_full;
  logic  sweeping;

  // accept and classify
  ctt_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .earlier_value(earlier_value), .later_value(later_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_full(q_full), .sweeping(sweeping), .busy(busy),
    .push(push), .push_item(push_item)
  );

  // request queue
  ctt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .empty(q_empty), .full(q_full)
  );

  // execute against the counter stores
  ctt_back #(.NUM_CLASSES(NUM_CLASSES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .head(head), .pop(pop),
    .sweeping(sweeping), .done(done), .status(status),
    .transition_code(transition_code), .cell_count(cell_count),
    .area_earlier(area_earlier), .area_later(area_later),
    .persistence_count(persistence_count), .gains_count(gains_count),
    .losses_count(losses_count), .net_delta(net_delta),
    .class_present(class_present)
  );

endmodule

// ----- design/ctt_checker.sv -----
// port-level checks for the class transition crosstab, bound to the top level
// depends on ctt_pkg and assert_macros.svh
`include "assert_macros.svh"

module ctt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                busy,
  input logic                                done,
  input logic [2:0]                          status,
  input logic [ctt_pkg::OUT_BITS-1:0]        cell_count,
  input logic [ctt_pkg::OUT_BITS-1:0]        area_earlier,
  input logic [ctt_pkg::OUT_BITS-1:0]        area_later,
  input logic [ctt_pkg::OUT_BITS-1:0]        persistence_count,
  input logic [ctt_pkg::OUT_BITS-1:0]        gains_count,
  input logic [ctt_pkg::OUT_BITS-1:0]        losses_count,
  input logic signed [ctt_pkg::NET_BITS-1:0] net_delta,
  input logic                                class_present
);
  import ctt_pkg::*;

  logic                       query_out;
  logic                       other_out;
  logic signed [NET_BITS-1:0] net_expect;
  logic                       diag_ok;
  logic                       stats_clear;

  // kinds of result on the strobe
  assign query_out = done && (status == ST_QUERY);
  assign other_out = done && (status != ST_QUERY);

  // expected relations among the answer fields
  assign net_expect  = $signed({1'b0, gains_count}) - $signed({1'b0, losses_count});
  assign diag_ok     = (persistence_count <= area_earlier) &&
                       (persistence_count <= area_later);
  assign stats_clear = (cell_count == '0) && (area_earlier == '0) && !class_present;

  // reset starts the clearing sweep, which holds requests off
  `CTT_ASSERT_NEXT(a_reset_sweep_busy, rst, busy)

  // net change agrees with the reported gains and losses
  `CTT_ASSERT_IMP(a_net_consistent, query_out, net_delta == net_expect)

  // the diagonal never exceeds either total of its class
  `CTT_ASSERT_IMP(a_diag_bounded, query_out, diag_ok)

  // only query answers carry statistics
  `CTT_ASSERT_IMP(a_stats_only_on_query, other_out, stats_clear)

endmodule

bind class_transition_crosstab ctt_checker u_ctt_checker (.*);

// ----- tb/sv/class_transition_crosstab_tb.sv -----
// testbench for class_transition_crosstab: count, query, clear and no-data masking
// checks every result against an in-bench mirror of the transition matrix and totals
// depends on ctt_pkg and the class_transition_crosstab rtl
`timescale 1ns / 1ps

module class_transition_crosstab_tb;
  import ctt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NCLS = NUM_CLASSES_DEF;

  // one expected answer from the block
  typedef struct packed {
    status_t              status;
    logic [CODE_BITS-1:0] code;
    logic [OUT_BITS-1:0]  cell_val;
    logic [OUT_BITS-1:0]  area_e;
    logic [OUT_BITS-1:0]  area_l;
    logic [OUT_BITS-1:0]  persist;
    logic [OUT_BITS-1:0]  gains;
    logic [OUT_BITS-1:0]  losses;
    logic [NET_BITS-1:0]  net;
    logic                 present;
  } crosstab_answer_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   command = CMD_NONE;
  logic [VALUE_BITS-1:0]        earlier_value = '0;
  logic [VALUE_BITS-1:0]        later_value = '0;
  logic                         cfg_write = 1'b0;
  logic                         cfg_index = REG_NODATA_ENABLE;
  logic [VALUE_BITS-1:0]        cfg_data = '0;
  logic                         done;
  logic [2:0]                   status;
  logic [CODE_BITS-1:0]         transition_code;
  logic [OUT_BITS-1:0]          cell_count;
  logic [OUT_BITS-1:0]          area_earlier;
  logic [OUT_BITS-1:0]          area_later;
  logic [OUT_BITS-1:0]          persistence_count;
  logic [OUT_BITS-1:0]          gains_count;
  logic [OUT_BITS-1:0]          losses_count;
  logic signed [NET_BITS-1:0]   net_delta;
  logic                         class_present;

  // mirror of the block's stores and configuration
  logic [OUT_BITS-1:0]   mirror_cells [NCLS][NCLS] = '{default: '0};
  logic [OUT_BITS-1:0]   mirror_rows [NCLS] = '{default: '0};
  logic [OUT_BITS-1:0]   mirror_cols [NCLS] = '{default: '0};
  logic                  mirror_seen [NCLS] = '{default: 1'b0};
  logic                  mirror_nd_en = 1'b0;
  logic [VALUE_BITS-1:0] mirror_nd_val = '0;

  crosstab_answer_t crosstab_answers [$];
  int               mismatch_count = 0;
  int               stall_cycles = 0;

  class_transition_crosstab uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .command           (command),
    .earlier_value     (earlier_value),
    .later_value       (later_value),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .done              (done),
    .status            (status),
    .transition_code   (transition_code),
    .cell_count        (cell_count),
    .area_earlier      (area_earlier),
    .area_later        (area_later),
    .persistence_count (persistence_count),
    .gains_count       (gains_count),
    .losses_count      (losses_count),
    .net_delta         (net_delta),
    .class_present     (class_present)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // counters stop at all ones
  function automatic logic [OUT_BITS-1:0] sat_up(logic [OUT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // update the mirror for one accepted request and queue its answer
  function automatic void tabulate_request(cmd_t c, logic [VALUE_BITS-1:0] e,
                                           logic [VALUE_BITS-1:0] l);
    crosstab_answer_t a;
    logic [OUT_BITS-1:0] diag;
    a = '0;
    case (c)
      CMD_NONE: begin
        return;
      end
      CMD_CLEAR: begin
        foreach (mirror_cells[i, j]) mirror_cells[i][j] = '0;
        foreach (mirror_rows[i]) begin
          mirror_rows[i] = '0;
          mirror_cols[i] = '0;
          mirror_seen[i] = 1'b0;
        end
        a.status = ST_CLEARED;
      end
      CMD_COUNT: begin
        if (mirror_nd_en && (e == mirror_nd_val || l == mirror_nd_val)) begin
          a.status = ST_NODATA;
          a.code = CODE_BITS'(mirror_nd_val);
        end else begin
          a.code = CODE_BITS'(int'(e) * CODE_SCALE + int'(l));
          if (e >= NCLS || l >= NCLS) begin
            a.status = ST_RANGE;
          end else begin
            mirror_cells[e][l] = sat_up(mirror_cells[e][l]);
            mirror_rows[e] = sat_up(mirror_rows[e]);
            mirror_cols[l] = sat_up(mirror_cols[l]);
            mirror_seen[e] = 1'b1;
            mirror_seen[l] = 1'b1;
            a.status = ST_COUNTED;
          end
        end
      end
      default: begin
        // query of one class
        if (e >= NCLS) begin
          a.status = ST_RANGE;
        end else begin
          diag = mirror_cells[e][e];
          a.status = ST_QUERY;
          a.cell_val = (l < NCLS) ? mirror_cells[e][l] : '0;
          a.area_e = mirror_rows[e];
          a.area_l = mirror_cols[e];
          a.persist = diag;
          a.gains = mirror_cols[e] - diag;
          a.losses = mirror_rows[e] - diag;
          a.net = {1'b0, a.gains} - {1'b0, a.losses};
          a.present = mirror_seen[e];
        end
      end
    endcase
    crosstab_answers.push_back(a);
  endfunction

  // send one request; start stays high on return so back-to-back requests need no gap
  task automatic send_request(cmd_t c, logic [VALUE_BITS-1:0] e, logic [VALUE_BITS-1:0] l,
                              bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    earlier_value <= e;
    later_value <= l;
    do @(posedge clk); while (busy);
    tabulate_request(c, e, l);
  endtask

  // stop sending, let every answer arrive, then give the block time to settle
  task automatic quiesce(int tail);
    start <= 1'b0;
    while (crosstab_answers.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [VALUE_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_NODATA_ENABLE) mirror_nd_en = data[0];
    else mirror_nd_val = data;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [NET_BITS-1:0] want, logic [NET_BITS-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result strobe with the oldest expected answer
  always @(posedge clk) begin
    crosstab_answer_t want;
    if (!rst && done) begin
      if (crosstab_answers.size() == 0) begin
        $error("result with no request pending: status %0d", status);
        mismatch_count++;
      end else begin
        want = crosstab_answers.pop_front();
        check_field("status", want.status, status);
        check_field("transition_code", want.code, transition_code);
        check_field("cell_count", want.cell_val, cell_count);
        check_field("area_earlier", want.area_e, area_earlier);
        check_field("area_later", want.area_l, area_later);
        check_field("persistence_count", want.persist, persistence_count);
        check_field("gains_count", want.gains, gains_count);
        check_field("losses_count", want.losses, losses_count);
        check_field("net_delta", want.net, net_delta);
        check_field("class_present", want.present, class_present);
      end
    end
  end

  // watchdog on cycles where neither a request nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // corner pairs, repeated pairs back to back, diagonal and off-diagonal
  task automatic test_basic_counts();
    send_request(CMD_COUNT, 16'd0, 16'd0, 1'b0);
    send_request(CMD_COUNT, 16'd15, 16'd15, 1'b0);
    send_request(CMD_COUNT, 16'd0, 16'd15, 1'b0);
    send_request(CMD_COUNT, 16'd15, 16'd0, 1'b0);
    send_request(CMD_COUNT, 16'd3, 16'd7, 1'b0);
    send_request(CMD_COUNT, 16'd3, 16'd7, 1'b0);
    send_request(CMD_COUNT, 16'd7, 16'd3, 1'b0);
    send_request(CMD_COUNT, 16'd7, 16'd7, 1'b0);
  endtask

  // statistics, unseen class, column and class out of range
  task automatic test_queries();
    send_request(CMD_QUERY, 16'd3, 16'd7, 1'b0);
    send_request(CMD_QUERY, 16'd15, 16'd0, 1'b0);
    send_request(CMD_QUERY, 16'd0, 16'd0, 1'b0);
    send_request(CMD_QUERY, 16'd7, 16'd3, 1'b0);
    send_request(CMD_QUERY, 16'd9, 16'd9, 1'b0);
    send_request(CMD_QUERY, 16'd5, 16'hFFFF, 1'b0);
    send_request(CMD_QUERY, 16'd16, 16'd0, 1'b0);
    send_request(CMD_QUERY, 16'hFFFF, 16'd0, 1'b0);
  endtask

  // out-of-range pairs are reported but not counted; the unused command is ignored
  task automatic test_range_and_ignored();
    send_request(CMD_COUNT, 16'd16, 16'd0, 1'b0);
    send_request(CMD_COUNT, 16'd0, 16'd16, 1'b0);
    send_request(CMD_COUNT, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b0);
  endtask

  // no-data masking on either side, and its precedence over range errors
  task automatic test_nodata();
    quiesce(300);
    write_reg(REG_NODATA_ENABLE, 16'd1);
    write_reg(REG_NODATA_VALUE, 16'd0);
    send_request(CMD_COUNT, 16'd0, 16'd5, 1'b0);
    send_request(CMD_COUNT, 16'd5, 16'd0, 1'b0);
    send_request(CMD_COUNT, 16'hFFFF, 16'd0, 1'b0);
    quiesce(300);
    write_reg(REG_NODATA_VALUE, 16'hFFFF);
    send_request(CMD_COUNT, 16'hFFFF, 16'd3, 1'b0);
    send_request(CMD_COUNT, 16'd4, 16'd4, 1'b0);
  endtask

  task automatic test_clear();
    send_request(CMD_CLEAR, 16'd0, 16'd0, 1'b0);
    send_request(CMD_QUERY, 16'd3, 16'd7, 1'b0);
  endtask

  // mostly in-range classes, sometimes the no-data value or any raw value
  function automatic logic [VALUE_BITS-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return VALUE_BITS'($urandom_range(0, NCLS - 1));
    if (r < 93) return VALUE_BITS'($urandom);
    return mirror_nd_val;
  endfunction

  // random mix of requests; ignored commands do not count toward n
  task automatic test_random_traffic(int n, bit gaps);
    int sent;
    int r;
    cmd_t c;
    logic [VALUE_BITS-1:0] e, l, last_e, last_l;
    sent = 0;
    last_e = '0;
    last_l = '0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 1) c = CMD_CLEAR;
      else if (r < 4) c = CMD_NONE;
      else if (r < 24) c = CMD_QUERY;
      else c = CMD_COUNT;
      case (c)
        CMD_COUNT: begin
          if ($urandom_range(0, 4) == 0) begin
            e = last_e;
            l = last_l;
          end else begin
            e = pick_pixel();
            l = pick_pixel();
          end
          last_e = e;
          last_l = l;
        end
        CMD_QUERY: begin
          e = ($urandom_range(0, 9) != 0) ? VALUE_BITS'($urandom_range(0, NCLS - 1))
                                          : VALUE_BITS'($urandom);
          l = ($urandom_range(0, 4) != 0) ? VALUE_BITS'($urandom_range(0, NCLS - 1))
                                          : VALUE_BITS'($urandom);
        end
        default: begin
          e = VALUE_BITS'($urandom);
          l = VALUE_BITS'($urandom);
        end
      endcase
      send_request(c, e, l, gaps);
      if (c != CMD_NONE) sent++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_counts();
    test_queries();
    test_range_and_ignored();
    test_nodata();
    test_clear();

    // random phases under several masking settings
    quiesce(300);
    write_reg(REG_NODATA_ENABLE, 16'd0);
    write_reg(REG_NODATA_VALUE, 16'd0);
    test_random_traffic(300, 1'b1);
    quiesce(300);
    write_reg(REG_NODATA_ENABLE, 16'd1);
    write_reg(REG_NODATA_VALUE, 16'd3);
    test_random_traffic(300, 1'b1);
    quiesce(300);
    write_reg(REG_NODATA_VALUE, 16'hFFFF);
    test_random_traffic(200, 1'b1);
    quiesce(300);
    write_reg(REG_NODATA_ENABLE, 16'd0);
    write_reg(REG_NODATA_VALUE, 16'd12);
    test_random_traffic(150, 1'b0);
    quiesce(20);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
